// ===== rtl/lhrf_pkg.sv =====
// Package with payload types, status codes and sizes for the row fill core.
`timescale 1ns / 1ps
package lhrf_pkg;

  localparam int unsigned MaxSamples = 32;

  localparam logic [1:0] KindUniform  = 2'd0;
  localparam logic [1:0] KindInterval = 2'd1;
  localparam logic [1:0] KindTriang   = 2'd2;
  localparam logic [1:0] KindLog      = 2'd3;

  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusBadCnt  = 3'd1;
  localparam logic [2:0] StatusBadKind = 3'd2;
  localparam logic [2:0] StatusDivZero = 3'd3;
  localparam logic [2:0] StatusLogBnd  = 3'd4;

  typedef struct packed {
    logic [1:0]         distribution_kind;
    logic signed [31:0] low_bound;
    logic signed [31:0] peak_value;
    logic signed [31:0] high_bound;
    logic [5:0]         sample_count;
    logic [5:0]         row_index;
  } req_t;

  typedef struct packed {
    logic [5:0]         row_number;
    logic [5:0]         sample_index;
    logic signed [31:0] sample_value;
    logic [2:0]         status;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    OpMul  = 2'd0,
    OpDiv  = 2'd1,
    OpSqrt = 2'd2
  } op_e;

  typedef struct packed {
    logic       start;
    op_e        op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [63:0] rem;
  } alu_rsp_t;

endpackage

// ===== rtl/latin_hypercube_row_fill_core.sv =====
// Top level of the row fill core: request sequencer around the shared unit.
`timescale 1ns / 1ps
// The block takes one request through req_i when start_i is high and busy_o
// is low. It then emits sample_count results on res_o, each for one cycle
// with valid_o high, in increasing sample index order, last set on the
// final one. An invalid request gives a single result with an error status.
// All arithmetic runs on one shared bit-serial unit (multiply, divide and
// square root), one operation at a time. Uniform and interval take two
// operations per sample, triangular about four, and log 60 operations for
// the two logarithms plus 32 to 62 per sample; this unit sets the rate.
// Error results are decided in the check state and registered onto res_o.
// Reset clears the sequencer and drops any row in flight. The receiver
// cannot stall: every result is taken in the cycle it is shown.
module latin_hypercube_row_fill_core import lhrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output res_t res_o
);

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StCheck = 5'd1;
  localparam logic [4:0] StUMul  = 5'd2;
  localparam logic [4:0] StUDiv  = 5'd3;
  localparam logic [4:0] StUOut  = 5'd4;
  localparam logic [4:0] StTWL   = 5'd5;
  localparam logic [4:0] StTWR   = 5'd6;
  localparam logic [4:0] StTBnd  = 5'd7;
  localparam logic [4:0] StTM1   = 5'd8;
  localparam logic [4:0] StTM2   = 5'd9;
  localparam logic [4:0] StTDv   = 5'd10;
  localparam logic [4:0] StTSq   = 5'd11;
  localparam logic [4:0] StTOut  = 5'd12;
  localparam logic [4:0] StLLog  = 5'd13;
  localparam logic [4:0] StLSq   = 5'd14;
  localparam logic [4:0] StLMul  = 5'd15;
  localparam logic [4:0] StLDiv  = 5'd16;
  localparam logic [4:0] StERt   = 5'd17;
  localparam logic [4:0] StEMul  = 5'd18;
  localparam logic [4:0] StEOut  = 5'd19;
  localparam logic [4:0] StWait  = 5'd20;

  logic [4:0]  st_q, st_d, ret_q, ret_d;
  req_t        rq_q, rq_d;
  logic signed [33:0] c_q, c_d;
  logic [63:0] w_q, w_d, l_q, l_d, r_q, r_d;
  logic [63:0] pq_q, pq_d, pr_q, pr_d, t1_q, t1_d, lo_q, lo_d, hi_q, hi_d;
  logic [5:0]  k_q, k_d, bk_q, bk_d;
  logic        side_q, side_d;
  logic        lb_q, lb_d;
  logic [4:0]  j_q, j_d;
  logic [63:0] m_q, m_d, lg_q, lg_d, la_q, la_d;
  logic [63:0] root_q, root_d, res_q, res_d, t_q, t_d;
  logic        neg_q, neg_d;
  logic        issued_q, issued_d;
  alu_req_t    areq;
  alu_rsp_t    arsp;
  logic        vld_q, vld_d;
  res_t        out_q, out_d;

  lhrf_alu u_alu (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(areq), .rsp_o(arsp));

  logic signed [33:0] d_s;
  logic [63:0] mag;
  logic [5:0]  n;
  logic [5:0]  bm;
  logic [63:0] e_sh;
  logic [63:0] v_sh;
  logic [4:0]  msb;
  logic        tri_rt;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 31; i++) begin
      if (rq_q.low_bound[i] && !lb_q) msb = 5'(i);
      if (rq_q.high_bound[i] && lb_q) msb = 5'(i);
    end
  end

  always_comb begin
    st_d = st_q; ret_d = ret_q; rq_d = rq_q; c_d = c_q;
    w_d = w_q; l_d = l_q; r_d = r_q; pq_d = pq_q; pr_d = pr_q;
    t1_d = t1_q; lo_d = lo_q; hi_d = hi_q; k_d = k_q; bk_d = bk_q;
    side_d = side_q; lb_d = lb_q; j_d = j_q; m_d = m_q; lg_d = lg_q;
    la_d = la_q; root_d = root_q; res_d = res_q; t_d = t_q; neg_d = neg_q;
    issued_d = issued_q;
    vld_d = 1'b0; out_d = out_q;
    areq = '0;
    n = rq_q.sample_count;
    d_s = 34'(rq_q.high_bound) - 34'(rq_q.low_bound);
    mag = d_s[33] ? 64'(-d_s) : 64'(d_s);
    bm = (bk_q == n) ? 6'd0 : 6'(n - bk_q);
    tri_rt = (39'(w_q[32:0]) * 39'(bk_q)) > (39'(n) * 39'(l_q[32:0]));
    e_sh = '0; v_sh = '0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          rq_d = req_i;
          st_d = StCheck;
        end
      end
      StCheck: begin
        out_d.row_number = rq_q.row_index;
        out_d.sample_index = '0;
        out_d.sample_value = '0;
        out_d.last = 1'b1;
        k_d = '0;
        neg_d = d_s[33];
        if (n == 6'd0 || 32'(n) >= MaxSamples) begin
          out_d.status = StatusBadCnt; vld_d = 1'b1; st_d = StIdle;
        end else if ((rq_q.distribution_kind == KindInterval ||
                      rq_q.distribution_kind == KindLog) && n == 6'd1) begin
          out_d.status = StatusBadCnt; vld_d = 1'b1; st_d = StIdle;
        end else if (rq_q.distribution_kind == KindLog &&
                     (rq_q.low_bound <= 0 || rq_q.high_bound <= 0)) begin
          out_d.status = StatusLogBnd; vld_d = 1'b1; st_d = StIdle;
        end else if (rq_q.distribution_kind == KindTriang &&
                     rq_q.high_bound <= rq_q.low_bound) begin
          out_d.status = StatusDivZero; vld_d = 1'b1; st_d = StIdle;
        end else begin
          out_d.status = StatusOk;
          c_d = 34'(rq_q.peak_value);
          if (rq_q.peak_value < rq_q.low_bound) c_d = 34'(rq_q.low_bound);
          if (rq_q.peak_value > rq_q.high_bound) c_d = 34'(rq_q.high_bound);
          w_d = mag;
          unique case (rq_q.distribution_kind)
            KindTriang: st_d = StTWL;
            KindLog: begin
              lb_d = 1'b0; st_d = StLLog;
            end
            default: st_d = StUMul;
          endcase
        end
      end
      StWait: begin
        if (arsp.done) st_d = ret_q;
      end
      StUMul: begin
        areq.start = 1'b1; areq.op = OpMul; areq.a = w_q;
        areq.b = (rq_q.distribution_kind == KindUniform) ?
                 64'({k_q, 1'b1}) : 64'(k_q);
        ret_d = StUDiv; st_d = StWait;
      end
      StUDiv: begin
        areq.start = 1'b1; areq.op = OpDiv; areq.a = arsp.res;
        areq.b = (rq_q.distribution_kind == KindUniform) ?
                 64'({n, 1'b0}) : 64'(n - 6'd1);
        ret_d = StUOut; st_d = StWait;
      end
      StUOut: begin
        out_d.sample_index = k_q;
        out_d.last = (k_q == n - 6'd1);
        out_d.sample_value = neg_q ? 32'(rq_q.low_bound - 32'(arsp.res))
                                   : 32'(rq_q.low_bound + 32'(arsp.res));
        if (rq_q.distribution_kind == KindInterval && k_q == n - 6'd1)
          out_d.sample_value = rq_q.high_bound;
        vld_d = 1'b1;
        k_d = k_q + 6'd1;
        st_d = (k_q == n - 6'd1) ? StIdle : StUMul;
      end
      StTWL: begin
        l_d = 64'(c_q - 34'(rq_q.low_bound));
        r_d = 64'(34'(rq_q.high_bound) - c_q);
        areq.start = 1'b1; areq.op = OpMul; areq.a = w_q;
        areq.b = 64'(c_q - 34'(rq_q.low_bound));
        ret_d = StTWR; st_d = StWait;
      end
      StTWR: begin
        if (!issued_q) begin
          t1_d = arsp.res;
          areq.start = 1'b1; areq.op = OpDiv; areq.a = arsp.res; areq.b = 64'(n);
          issued_d = 1'b1; ret_d = StTWR; st_d = StWait;
        end else begin
          pq_d = arsp.res; pr_d = arsp.rem;
          areq.start = 1'b1; areq.op = OpMul; areq.a = w_q; areq.b = r_q;
          issued_d = 1'b0; ret_d = StTBnd; st_d = StWait;
          hi_d = '0;
        end
      end
      StTBnd: begin
        if (k_q == 6'd0 && !side_q) begin
          t1_d = arsp.res; side_d = 1'b1;
          areq.start = 1'b1; areq.op = OpDiv; areq.a = arsp.res; areq.b = 64'(n);
          ret_d = StTBnd; st_d = StWait;
        end else begin
          if (k_q == 6'd0) begin
            lo_d = arsp.res; hi_d = arsp.rem;
          end
          bk_d = k_q; st_d = StTM1; issued_d = 1'b0;
        end
      end
      StTM1: begin
        side_d = tri_rt;
        areq.start = 1'b1; areq.op = OpMul;
        areq.a = tri_rt ? lo_q : pq_q;
        areq.b = tri_rt ? 64'(bm) : 64'(bk_q);
        ret_d = StTM2; st_d = StWait;
      end
      StTM2: begin
        t1_d = arsp.res;
        areq.start = 1'b1; areq.op = OpMul;
        areq.a = side_q ? hi_q : pr_q;
        areq.b = side_q ? 64'(bm) : 64'(bk_q);
        ret_d = StTDv; st_d = StWait;
      end
      StTDv: begin
        areq.start = 1'b1; areq.op = OpDiv; areq.a = arsp.res; areq.b = 64'(n);
        ret_d = StTSq; st_d = StWait;
      end
      StTSq: begin
        areq.start = 1'b1; areq.op = OpSqrt; areq.a = t1_q + arsp.res;
        ret_d = StTOut; st_d = StWait;
      end
      StTOut: begin
        m_d = side_q ? w_q - arsp.res : arsp.res;
        if (bk_q == k_q && !issued_q) begin
          root_d = side_q ? w_q - arsp.res : arsp.res;
          issued_d = 1'b1;
          bk_d = k_q + 6'd1; st_d = StTM1;
        end else begin
          out_d.sample_index = k_q;
          out_d.last = (k_q == n - 6'd1);
          out_d.sample_value = 32'(rq_q.low_bound +
            32'((root_q + (side_q ? w_q - arsp.res : arsp.res)) >> 1));
          vld_d = 1'b1;
          root_d = side_q ? w_q - arsp.res : arsp.res;
          k_d = k_q + 6'd1; bk_d = k_q + 6'd2;
          st_d = (k_q == n - 6'd1) ? StIdle : StTM1;
        end
      end
      StLLog: begin
        lg_d = 64'(msb) << 30;
        m_d = (lb_q ? 64'(rq_q.high_bound) : 64'(rq_q.low_bound)) << 30 >> msb;
        j_d = 5'd29; st_d = StLSq; issued_d = 1'b0;
      end
      StLSq: begin
        if (!issued_q) begin
          areq.start = 1'b1; areq.op = OpMul; areq.a = m_q; areq.b = m_q;
          issued_d = 1'b1; ret_d = StLSq; st_d = StWait;
        end else begin
          issued_d = 1'b0;
          m_d = arsp.res >> 30;
          if ((arsp.res >> 30) >= (64'd1 << 31)) begin
            m_d = arsp.res >> 31;
            lg_d = lg_q | (64'd1 << j_q);
          end
          j_d = j_q - 5'd1;
          if (j_q == 5'd0) begin
            if (!lb_q) begin
              la_d = ((arsp.res >> 30) >= (64'd1 << 31)) ? lg_q | 64'd1 : lg_q;
              lb_d = 1'b1; st_d = StLLog;
            end else begin
              t_d = ((arsp.res >> 30) >= (64'd1 << 31)) ? lg_q | 64'd1 : lg_q;
              st_d = StLMul;
            end
          end
        end
      end
      StLMul: begin
        neg_d = t_q < la_q;
        areq.start = 1'b1; areq.op = OpMul;
        areq.a = (t_q < la_q) ? la_q - t_q : t_q - la_q; areq.b = 64'(k_q);
        ret_d = StLDiv; st_d = StWait;
      end
      StLDiv: begin
        areq.start = 1'b1; areq.op = OpDiv; areq.a = arsp.res; areq.b = 64'(n - 6'd1);
        ret_d = StERt; st_d = StWait;
        j_d = 5'd1; root_d = 64'd1 << 31; res_d = 64'd1 << 30; issued_d = 1'b0;
      end
      StERt: begin
        if (j_q == 5'd1 && !issued_q) hi_d = neg_q ? la_q - arsp.res : la_q + arsp.res;
        if (!issued_q) begin
          areq.start = 1'b1; areq.op = OpSqrt; areq.a = root_q << 30;
          issued_d = 1'b1; ret_d = StERt; st_d = StWait;
        end else begin
          issued_d = 1'b0;
          root_d = arsp.res;
          if (hi_q[30 - 32'(j_q)]) begin
            areq.start = 1'b1; areq.op = OpMul; areq.a = res_q; areq.b = arsp.res;
            ret_d = StEMul; st_d = StWait;
          end else begin
            st_d = (j_q == 5'd30) ? StEOut : StERt;
            j_d = j_q + 5'd1;
          end
        end
      end
      StEMul: begin
        res_d = arsp.res >> 30;
        st_d = (j_q == 5'd30) ? StEOut : StERt;
        j_d = j_q + 5'd1;
      end
      StEOut: begin
        e_sh = hi_q >> 30;
        v_sh = (res_q << e_sh[5:0]) >> 30;
        out_d.sample_index = k_q;
        out_d.last = (k_q == n - 6'd1);
        out_d.sample_value = (e_sh > 64'd30 || v_sh > 64'h7FFF_FFFF) ?
                             32'h7FFF_FFFF : v_sh[31:0];
        vld_d = 1'b1;
        k_d = k_q + 6'd1;
        st_d = (k_q == n - 6'd1) ? StIdle : StLMul;
      end
      default: st_d = StIdle;
    endcase
    if (st_q == StCheck && rq_q.distribution_kind == KindTriang) begin
      side_d = 1'b0; issued_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ret_q <= StIdle; vld_q <= 1'b0;
      issued_q <= 1'b0; side_q <= 1'b0; lb_q <= 1'b0;
    end else begin
      st_q <= st_d; ret_q <= ret_d; vld_q <= vld_d;
      issued_q <= issued_d; side_q <= side_d; lb_q <= lb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; c_q <= c_d; w_q <= w_d; l_q <= l_d; r_q <= r_d;
    pq_q <= pq_d; pr_q <= pr_d; t1_q <= t1_d; lo_q <= lo_d; hi_q <= hi_d;
    k_q <= k_d; bk_q <= bk_d; j_q <= j_d; m_q <= m_d; lg_q <= lg_d;
    la_q <= la_d; root_q <= root_d; res_q <= res_d; t_q <= t_d;
    neg_q <= neg_d; out_q <= out_d;
  end

  assign busy_o  = (st_q != StIdle);
  assign valid_o = vld_q;
  assign res_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.status != StatusOk) |-> res_o.last)
    else $error("error result without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.last) |-> !busy_o)
    else $error("busy after last result");

endmodule

// ===== rtl/lhrf_alu.sv =====
// Shared multi-cycle unit: 64-bit multiply, divide and square root, bit serial.
`timescale 1ns / 1ps
module lhrf_alu import lhrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  op_e         op_q, op_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d, rem_q, rem_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [65:0] strial;
  logic [65:0] srem;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    trial  = '0;
    strial = '0;
    srem   = '0;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        a_d    = req_i.a;
        b_d    = req_i.b;
        acc_d  = '0;
        rem_d  = '0;
        cnt_d  = (req_i.op == OpSqrt) ? 7'd32 : 7'd64;
      end
    end else begin
      unique case (op_q)
        OpMul: begin
          if (b_q[0]) acc_d = acc_q + a_q;
          a_d = {a_q[62:0], 1'b0};
          b_d = {1'b0, b_q[63:1]};
        end
        OpDiv: begin
          trial = {rem_q, a_q[63]};
          a_d   = {a_q[62:0], 1'b0};
          if (trial >= {1'b0, b_q}) begin
            rem_d = 64'(trial - {1'b0, b_q});
            acc_d = {acc_q[62:0], 1'b1};
          end else begin
            rem_d = trial[63:0];
            acc_d = {acc_q[62:0], 1'b0};
          end
        end
        default: begin
          srem   = {rem_q, a_q[63:62]};
          strial = {acc_q, 2'b01};
          a_d    = {a_q[61:0], 2'b00};
          if (srem >= strial) begin
            rem_d = 64'(srem - strial);
            acc_d = {acc_q[62:0], 1'b1};
          end else begin
            rem_d = srem[63:0];
            acc_d = {acc_q[62:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OpMul;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;
  assign rsp_o.rem  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("alu done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != 7'd0)
    else $error("alu busy with zero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1) |=> done_q)
    else $error("alu missed done");

endmodule
